// ===== hdl/rbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbc_pkg: shared types and constants for the per-byte RSA cipher
// Widths, register indexes, the fold step and the multiply unit's interface.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int BYTE_W  = 8;
    localparam int FOLD_W  = 10;
    localparam int REG_W   = 16;
    localparam int MOD_W   = REG_W + 1;   // effective modulus reaches 65536
    localparam int IDX_W   = 2;

    localparam logic [6:0] FOLD_STEP = 7'd126;

    // floor(y / 63) = (y * FOLD_RECIP) >> FOLD_SHIFT, exact for y below 32768
    localparam logic [REG_W-1:0] FOLD_RECIP = 16'd33289;
    localparam int               FOLD_SHIFT = 21;
    localparam int               RECIP_W    = 31;

    localparam logic [IDX_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PUB_EXP  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

    localparam logic [REG_W-1:0] MODULUS_RST = 16'd2;

    typedef enum logic {
        FUNC_ENCRYPT = 1'b0,
        FUNC_DECRYPT = 1'b1
    } func_t;

    // request to the shared multiply-reduce unit: p = (a * b) mod m
    typedef struct packed {
        logic             start;
        logic [REG_W-1:0] a;
        logic [MOD_W-1:0] b;
        logic [MOD_W-1:0] m;
    } mm_req_t;

    typedef struct packed {
        logic             done;
        logic [REG_W-1:0] p;
    } mm_rsp_t;

endpackage

// ===== hdl/rbc_modmul.sv =====
// ----------------------------------------------------------------------------
// rbc_modmul: bit-serial modular multiplier
// Interleaved shift-add: one bit of b per cycle, MSB first, with the running
// value kept below m by a compare-subtract after the double and the add.
// ----------------------------------------------------------------------------
module rbc_modmul
    import rbc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    localparam int CNT_W = $clog2(MOD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REG_W-1:0] acc_reg, acc_next;
    logic [REG_W-1:0] a_reg, a_next;
    logic [MOD_W-1:0] b_reg, b_next;
    logic [MOD_W-1:0] m_reg, m_next;

    logic [MOD_W-1:0] dbl, red1, addend, sum, red2;

    always_comb begin
        dbl    = {acc_reg, 1'b0};
        red1   = (dbl >= m_reg) ? dbl - m_reg : dbl;
        addend = b_reg[MOD_W-1] ? {1'b0, a_reg} : '0;
        sum    = red1 + addend;
        red2   = (sum >= m_reg) ? sum - m_reg : sum;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        if (busy_reg) begin
            acc_next = red2[REG_W-1:0];
            b_next   = {b_reg[MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MOD_W - 1);
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            m_next    = req.m;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

// ===== hdl/rsa_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// rsa_byte_cipher: per-byte toy RSA with fold step
// Modular exponentiation on one shared bit-serial multiply-reduce unit.
// ----------------------------------------------------------------------------
// Usage:
//   Write modulus, public and private exponent through the cfg channel
//   (cfg_index 0..2, cfg_data 16 bits) while the block is idle; cfg_ready
//   is always high, other indexes are ignored. Modulus 0 means 65536.
//   s_ channel: one request = func, data_byte, fold_in. s_ready is high only
//   while no request is in work; one request is worked at a time.
//   m_ channel: result_byte and fold_out, held in an output register until
//   taken, so the next request is accepted while a result still waits.
// Cost: every modular multiplication runs 17 steps on the shared unit.
//   A request costs one reduction of the input, 15 squarings, one multiply
//   per set exponent bit, one pass through the issue state per exponent
//   bit and the fold division when encrypting to a value above 126.
//   s_ready returns in the same cycle as m_valid is set for the result.
// Reset: registers return to modulus 2, exponents 0; no request in work
//   and no result pending. A stalled receiver holds the finished result in
//   the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module rsa_byte_cipher
    import rbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [BYTE_W-1:0] s_data_byte,
    input  logic [FOLD_W-1:0] s_fold_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_result_byte,
    output logic [FOLD_W-1:0] m_fold_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BASE = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_FOLD = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam int BIT_W = $clog2(REG_W);

    logic [REG_W-1:0] modulus_reg, pub_exp_reg, priv_exp_reg;

    logic [2:0]        state_reg, state_next;
    func_t             func_reg, func_next;
    logic [REG_W-1:0]  exp_reg, exp_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [REG_W-1:0]  one_reg, one_next;
    logic [REG_W-1:0]  acc_reg, acc_next;
    logic [REG_W-1:0]  base_reg, base_next;
    logic [REG_W-1:0]  div_x_reg, div_x_next;
    logic [FOLD_W-1:0] quo_reg, quo_next;
    logic [BYTE_W-1:0] res_byte_reg, res_byte_next;
    logic [FOLD_W-1:0] res_fold_reg, res_fold_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic [FOLD_W-1:0] m_fold_reg, m_fold_next;
    mm_req_t           mm_req_reg, mm_req_next;
    mm_rsp_t           mm_rsp;

    logic [MOD_W-1:0]   t_in;
    logic [RECIP_W-1:0] recip_prod;
    logic [REG_W-1:0]   fold_mul;
    logic               s_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_result_byte = m_byte_reg;
    assign m_fold_out    = m_fold_reg;

    // rebuilt decrypt input, up to 17 bits
    assign t_in  = MOD_W'(s_data_byte) + MOD_W'(FOLD_STEP) * MOD_W'(s_fold_in);
    // (k - 1) / 126 = ((k - 1) >> 1) / 63
    assign recip_prod = RECIP_W'(div_x_reg[REG_W-1:1]) * RECIP_W'(FOLD_RECIP);
    assign fold_mul   = REG_W'(quo_reg) * REG_W'(FOLD_STEP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= MODULUS_RST;
            pub_exp_reg  <= '0;
            priv_exp_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODULUS:  modulus_reg  <= cfg_data;
                CFG_PUB_EXP:  pub_exp_reg  <= cfg_data;
                CFG_PRIV_EXP: priv_exp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        exp_next      = exp_reg;
        bit_next      = bit_reg;
        one_next      = one_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        div_x_next    = div_x_reg;
        quo_next      = quo_reg;
        res_byte_next = res_byte_reg;
        res_fold_next = res_fold_reg;
        m_valid_next  = m_valid_reg;
        m_byte_next   = m_byte_reg;
        m_fold_next   = m_fold_reg;
        mm_req_next   = mm_req_reg;
        mm_req_next.start = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    func_next = func_t'(s_func);
                    exp_next  = (s_func == FUNC_DECRYPT) ? priv_exp_reg : pub_exp_reg;
                    one_next  = (modulus_reg == REG_W'(1)) ? '0 : REG_W'(1);
                    // reduce the input t (t_in or the data byte): (1 mod m) * t mod m
                    mm_req_next.start = 1'b1;
                    mm_req_next.a = (modulus_reg == REG_W'(1)) ? '0 : REG_W'(1);
                    mm_req_next.b = (s_func == FUNC_DECRYPT) ? t_in : MOD_W'(s_data_byte);
                    mm_req_next.m = (modulus_reg == '0) ? {1'b1, {REG_W{1'b0}}}
                                                        : {1'b0, modulus_reg};
                    state_next = S_BASE;
                end
            end
            S_BASE: begin
                if (mm_rsp.done) begin
                    base_next  = mm_rsp.p;
                    acc_next   = one_reg;
                    bit_next   = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (exp_reg[0]) begin
                    mm_req_next.start = 1'b1;
                    mm_req_next.a = acc_reg;
                    mm_req_next.b = MOD_W'(base_reg);
                    state_next = S_MUL;
                end else if (bit_reg == '1) begin
                    state_next = S_FIN;
                end else begin
                    mm_req_next.start = 1'b1;
                    mm_req_next.a = base_reg;
                    mm_req_next.b = MOD_W'(base_reg);
                    state_next = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_rsp.done) begin
                    acc_next = mm_rsp.p;
                    if (bit_reg == '1) begin
                        state_next = S_FIN;
                    end else begin
                        mm_req_next.start = 1'b1;
                        mm_req_next.a = base_reg;
                        mm_req_next.b = MOD_W'(base_reg);
                        state_next = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mm_rsp.done) begin
                    base_next  = mm_rsp.p;
                    exp_next   = {1'b0, exp_reg[REG_W-1:1]};
                    bit_next   = bit_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_FIN: begin
                if (func_reg == FUNC_ENCRYPT && acc_reg > REG_W'(FOLD_STEP)) begin
                    // fold count = (k - 1) / 126, remainder restored to 1..126
                    div_x_next = acc_reg - 1'b1;
                    quo_next   = '0;
                    bit_next   = '0;
                    state_next = S_FOLD;
                end else begin
                    res_byte_next = acc_reg[BYTE_W-1:0];
                    res_fold_next = '0;
                    state_next    = S_DONE;
                end
            end
            S_FOLD: begin
                if (bit_reg == '0) begin
                    quo_next = recip_prod[RECIP_W-1:FOLD_SHIFT];
                    bit_next = bit_reg + 1'b1;
                end else begin
                    res_byte_next = BYTE_W'(div_x_reg - fold_mul) + 1'b1;
                    res_fold_next = quo_reg;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = res_byte_reg;
                    m_fold_next  = res_fold_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            mm_req_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mm_req_reg  <= mm_req_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        exp_reg      <= exp_next;
        bit_reg      <= bit_next;
        one_reg      <= one_next;
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        div_x_reg    <= div_x_next;
        quo_reg      <= quo_next;
        res_byte_reg <= res_byte_next;
        res_fold_reg <= res_fold_next;
        m_byte_reg   <= m_byte_next;
        m_fold_reg   <= m_fold_next;
    end

    rbc_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req_reg),
        .rsp     (mm_rsp)
    );

endmodule

// ===== hdl/rbc_checker.sv =====
// ----------------------------------------------------------------------------
// rbc_checker: port-level checks for the per-byte RSA cipher
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module rbc_checker
    import rbc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_result_byte,
    input logic [FOLD_W-1:0] m_fold_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_byte) && $stable(m_fold_out))
        else $error("result changed while stalled");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // no result can appear right after a request is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !(m_valid && !$past(m_valid)))
        else $error("result appeared too early");

    // a folded value lies in 1..126
    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fold_out != '0 |->
            m_result_byte != '0 && m_result_byte <= BYTE_W'(FOLD_STEP))
        else $error("folded byte out of range");

endmodule

bind rsa_byte_cipher rbc_checker u_rbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_byte (m_result_byte),
    .m_fold_out    (m_fold_out)
);

// ===== verif/tb_rsa_byte_cipher.sv =====
// ----------------------------------------------------------------------------
// tb_rsa_byte_cipher: self-checking testbench for the per-byte RSA cipher
// Sends encrypt and decrypt requests under several key settings, predicts
// each result with a behavioral square-and-multiply model, and compares
// every returned byte and fold count in order. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rsa_byte_cipher;
    import rbc_pkg::*;

    localparam int               CLK_HALF   = 6;
    localparam int               IDLE_LIMIT = 6000;
    localparam int               DRAIN_CYC  = 700;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic [FOLD_W-1:0] fold_out;
    } cipher_out_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index   = '0;
    logic [REG_W-1:0]  cfg_data    = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic              s_func      = 1'b0;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic [FOLD_W-1:0] s_fold_in   = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [BYTE_W-1:0] m_result_byte;
    logic [FOLD_W-1:0] m_fold_out;

    // shadow copy of the key registers
    logic [REG_W-1:0] key_modulus  = MODULUS_RST;
    logic [REG_W-1:0] key_pub_exp  = '0;
    logic [REG_W-1:0] key_priv_exp = '0;

    cipher_out_t expected_out[$];
    int          error_count = 0;
    bit          no_idle     = 1'b0;
    int          idle_cycles = 0;

    rsa_byte_cipher dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_data_byte   (s_data_byte),
        .s_fold_in     (s_fold_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte),
        .m_fold_out    (m_fold_out)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // (base ^ ex) mod m over 16 exponent bits
    function automatic logic [MOD_W-1:0] pow_mod(input logic [17:0] base,
                                                 input logic [REG_W-1:0] ex,
                                                 input logic [MOD_W-1:0] m);
        logic [33:0] acc;
        logic [33:0] sq;
        acc = 34'd1 % m;
        sq  = base % m;
        for (int i = 0; i < REG_W; i++) begin
            if (ex[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[MOD_W-1:0];
    endfunction

    function automatic cipher_out_t cipher_predict(input func_t op,
                                                   input logic [BYTE_W-1:0] byte_v,
                                                   input logic [FOLD_W-1:0] fold_v);
        logic [MOD_W-1:0] m;
        logic [MOD_W-1:0] k;
        logic [17:0]      t;
        cipher_out_t      r;
        m = (key_modulus == '0) ? 17'd65536 : {1'b0, key_modulus};
        r.fold_out = '0;
        if (op == FUNC_ENCRYPT) begin
            k = pow_mod({10'd0, byte_v}, key_pub_exp, m);
            if (k > FOLD_STEP) begin
                r.fold_out = FOLD_W'((k - 17'd1) / FOLD_STEP);
                k = k - FOLD_STEP * r.fold_out;
            end
        end else begin
            t = 18'(byte_v) + 18'(FOLD_STEP) * 18'(fold_v);
            k = pow_mod(t, key_priv_exp, m);
        end
        r.result_byte = k[BYTE_W-1:0];
        return r;
    endfunction

    // send one request; returns the predicted result
    task automatic send_request(input func_t op, input logic [BYTE_W-1:0] byte_v,
                                input logic [FOLD_W-1:0] fold_v,
                                output cipher_out_t predicted);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= op;
        s_data_byte <= byte_v;
        s_fold_in   <= fold_v;
        do @(posedge aclk); while (!s_ready);
        predicted = cipher_predict(op, byte_v, fold_v);
        expected_out.push_back(predicted);
    endtask

    // drop valid and wait until every result is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge aclk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MODULUS:  key_modulus  = value;
            CFG_PUB_EXP:  key_pub_exp  = value;
            CFG_PRIV_EXP: key_priv_exp = value;
            default: ;
        endcase
    endtask

    task automatic load_keys(input logic [REG_W-1:0] n, input logic [REG_W-1:0] e,
                             input logic [REG_W-1:0] d);
        wait_idle();
        write_reg(CFG_MODULUS, n);
        write_reg(CFG_PUB_EXP, e);
        write_reg(CFG_PRIV_EXP, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_keys();
        cipher_out_t r;
        send_request(FUNC_ENCRYPT, 8'd0, 10'd0, r);
        send_request(FUNC_ENCRYPT, 8'hFF, 10'h3FF, r);
        send_request(FUNC_DECRYPT, 8'h5A, 10'h155, r);
    endtask

    task automatic test_extreme_keys();
        logic [REG_W-1:0] n;
        logic [REG_W-1:0] ex;
        cipher_out_t      r;
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: begin n = 16'd1;     ex = 16'hFFFF; end
                1: begin n = 16'd0;     ex = 16'hFFFF; end
                2: begin n = 16'hFFFF;  ex = 16'd0;    end
                default: begin n = 16'd2; ex = 16'h5555; end
            endcase
            load_keys(n, ex, ~ex);
            if (s == 1) begin
                // an unused index must leave the keys alone
                write_reg(CFG_UNUSED, 16'h1234);
                cfg_valid <= 1'b0;
            end
            send_request(FUNC_ENCRYPT, 8'd0, 10'd0, r);
            send_request(FUNC_ENCRYPT, 8'hFF, 10'h2AA, r);
            send_request(FUNC_ENCRYPT, 8'hAA, 10'h155, r);
            send_request(FUNC_DECRYPT, 8'h55, 10'h3FF, r);
            send_request(FUNC_DECRYPT, 8'hFF, 10'h2AA, r);
            send_request(FUNC_DECRYPT, 8'd0, 10'h155, r);
        end
    endtask

    // encrypt, then decrypt with the predicted byte and fold count
    task automatic run_round_trips(input logic [REG_W-1:0] n, input logic [REG_W-1:0] e,
                                   input logic [REG_W-1:0] d, input int pairs);
        cipher_out_t enc;
        cipher_out_t r;
        logic [BYTE_W-1:0] b;
        logic [FOLD_W-1:0] f;
        load_keys(n, e, d);
        for (int i = 0; i < pairs; i++) begin
            send_request(FUNC_ENCRYPT, BYTE_W'($urandom_range(0, 255)), 10'($urandom), enc);
            b = enc.result_byte;
            f = enc.fold_out;
            // corrupt a few pairs
            if ($urandom_range(0, 9) == 0) begin
                b = b ^ BYTE_W'($urandom_range(1, 255));
            end else if ($urandom_range(0, 9) == 0) begin
                f = f ^ FOLD_W'($urandom_range(1, 1023));
            end
            send_request(FUNC_DECRYPT, b, f, r);
        end
    endtask

    task automatic test_key_round_trips();
        run_round_trips(16'd3233, 16'd17, 16'd2753, 60);
        no_idle = 1'b1;
        run_round_trips(16'd60491, 16'd7, 16'd17143, 60);
        no_idle = 1'b0;
        run_round_trips(16'd64507, 16'd3, 16'd42667, 60);
    endtask

    function automatic logic [REG_W-1:0] pick_reg_value(input bit is_mod);
        case ($urandom_range(0, 7))
            0: return is_mod ? 16'd1 : 16'd0;
            1: return 16'hFFFF;
            2: return is_mod ? 16'd0 : 16'd1;
            3: return 16'($urandom_range(2, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random_requests();
        cipher_out_t r;
        func_t       op;
        for (int p = 0; p < 8; p++) begin
            load_keys(pick_reg_value(1'b1), pick_reg_value(1'b0), pick_reg_value(1'b0));
            no_idle = (p == 3);
            for (int i = 0; i < 80; i++) begin
                op = func_t'($urandom_range(0, 1));
                send_request(op, BYTE_W'($urandom), FOLD_W'($urandom), r);
            end
        end
        no_idle = 1'b0;
    endtask

    // receiver: check each accepted result, stall at random
    initial begin
        cipher_out_t want;
        int          stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected result: result_byte %0d fold_out %0d",
                           m_result_byte, m_fold_out);
                    error_count++;
                end else begin
                    want = expected_out.pop_front();
                    if (m_result_byte !== want.result_byte) begin
                        $error("result_byte: expected %0d, actual %0d",
                               want.result_byte, m_result_byte);
                        error_count++;
                    end
                    if (m_fold_out !== want.fold_out) begin
                        $error("fold_out: expected %0d, actual %0d",
                               want.fold_out, m_fold_out);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_keys();
        test_extreme_keys();
        test_key_round_trips();
        test_random_requests();
        wait_idle();
        repeat (DRAIN_CYC) @(posedge aclk);
        if (error_count == 0 && expected_out.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
